>>> rtl/core/gle_pkg.sv
// gle_pkg: shared types and constants for the glyph layout engine
// holds the glyph entry layout, request kinds and character codes
// no dependencies
`default_nettype none

package gle_pkg;

  localparam int unsigned GlyphEntriesDefault = 256;

  // request kinds carried on tuser
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_BEGIN = 2'd1,
    OP_CHAR  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_METRIC  = 8'h6A;
  localparam logic [7:0] LINE_GAP   = 8'd2;

  localparam int unsigned InDataW  = 104;
  localparam int unsigned OutDataW = 104;

  // atlas_x sits in the lowest bits
  typedef struct packed {
    logic [7:0]        advance;
    logic signed [7:0] offset_y;
    logic signed [7:0] offset_x;
    logic [7:0]        height;
    logic [7:0]        width;
    logic [11:0]       atlas_y;
    logic [11:0]       atlas_x;
  } glyph_t;

endpackage

`default_nettype wire

>>> rtl/core/glyph_layout_engine.sv
// A result passes the glyph table read register, then the result register,
// after its character request is accepted. Throughput: one request per cycle
// unless out_tready holds a full result register; the registered table read
// and one pass of adders and saturation logic set that figure.
// Reset clears the cursor, origin, bounds and the per-entry valid bits of the
// glyph table at once, so every entry reads as zero until loaded.
`default_nettype none

module glyph_layout_engine
  import gle_pkg::*;
#(
  parameter int unsigned GLYPH_ENTRIES = GlyphEntriesDefault
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  // code, atlas_x, atlas_y, glyph_width, glyph_height, offset_x, offset_y,
  // advance, origin_x, origin_y
  input  wire logic [InDataW-1:0]  in_tdata,
  // operation
  input  wire logic [1:0]          in_tuser,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  // src_x, src_y, quad_width, quad_height, dest_x, dest_y, extent_w, extent_h
  output logic [OutDataW-1:0]      out_tdata
);

  localparam int unsigned AW = $clog2(GLYPH_ENTRIES);

  // input unpack
  logic [7:0]         in_code;
  glyph_t             in_glyph;
  logic signed [15:0] in_origin_x;
  logic signed [15:0] in_origin_y;
  logic               in_range;
  logic               in_acc;
  logic               adv;

  assign in_code           = in_tdata[7:0];
  assign in_glyph.atlas_x  = in_tdata[19:8];
  assign in_glyph.atlas_y  = in_tdata[31:20];
  assign in_glyph.width    = in_tdata[39:32];
  assign in_glyph.height   = in_tdata[47:40];
  assign in_glyph.offset_x = in_tdata[55:48];
  assign in_glyph.offset_y = in_tdata[63:56];
  assign in_glyph.advance  = in_tdata[71:64];
  assign in_origin_x       = in_tdata[87:72];
  assign in_origin_y       = in_tdata[103:88];
  assign in_range          = ({1'b0, in_code} < 9'(GLYPH_ENTRIES));

  // glyph table with valid bits
  glyph_t                   glyph_mem [GLYPH_ENTRIES];
  logic [GLYPH_ENTRIES-1:0] valid_r;
  glyph_t                   rd_r;

  // read stage
  logic               s1_valid_r;
  op_t                s1_op_r;
  logic [7:0]         s1_code_r;
  logic               s1_hit_r;
  logic [7:0]         s1_ld_height_r;
  logic [7:0]         s1_ld_adv_r;
  logic               s1_ld_metric_r;
  logic signed [15:0] s1_origin_x_r;
  logic signed [15:0] s1_origin_y_r;

  // layout state
  logic signed [15:0] cursor_x_r, cursor_x_nxt;
  logic signed [15:0] cursor_y_r, cursor_y_nxt;
  logic signed [15:0] start_x_r, start_x_nxt;
  logic signed [15:0] start_y_r, start_y_nxt;
  logic [15:0]        box_w_r, box_w_nxt;
  logic [15:0]        box_h_r, box_h_nxt;
  logic [7:0]         j_adv_r, j_adv_nxt;
  logic [7:0]         j_height_r, j_height_nxt;

  // result register
  logic               out_valid_r;
  logic [OutDataW-1:0] out_data_r;
  logic               emit;
  logic [OutDataW-1:0] out_data_nxt;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  function automatic logic signed [15:0] sat_s16(input logic signed [17:0] v);
    if (v > 18'sd32767) begin
      return 16'sh7FFF;
    end else if (v < -18'sd32768) begin
      return 16'sh8000;
    end else begin
      return v[15:0];
    end
  endfunction

  function automatic logic [15:0] sat_u16(input logic signed [17:0] v);
    if (v < 18'sd0) begin
      return 16'h0000;
    end else if (v > 18'sd65535) begin
      return 16'hFFFF;
    end else begin
      return v[15:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (in_acc && op_t'(in_tuser) == OP_LOAD && in_range) begin
      glyph_mem[in_code[AW-1:0]] <= in_glyph;
    end
    if (in_acc) begin
      rd_r <= glyph_mem[in_code[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (in_acc && op_t'(in_tuser) == OP_LOAD && in_range) begin
      valid_r[in_code[AW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r        <= op_t'(in_tuser);
      s1_code_r      <= in_code;
      s1_hit_r       <= in_range && valid_r[in_code[AW-1:0]];
      s1_ld_height_r <= in_glyph.height;
      s1_ld_adv_r    <= in_glyph.advance;
      s1_ld_metric_r <= in_range && (in_code == CH_METRIC);
      s1_origin_x_r  <= in_origin_x;
      s1_origin_y_r  <= in_origin_y;
    end
  end

  // layout pass
  glyph_t             g;
  logic signed [17:0] cx_ext, cy_ext, sx_ext, sy_ext;
  logic signed [17:0] rel;
  logic signed [17:0] jadv_ext, jh_ext;

  always_comb begin
    g             = s1_hit_r ? rd_r : '0;
    cx_ext        = 18'(cursor_x_r);
    cy_ext        = 18'(cursor_y_r);
    sx_ext        = 18'(start_x_r);
    sy_ext        = 18'(start_y_r);
    jadv_ext      = $signed({10'd0, j_adv_r});
    jh_ext        = $signed({10'd0, j_height_r});
    rel           = cx_ext - sx_ext;

    cursor_x_nxt  = cursor_x_r;
    cursor_y_nxt  = cursor_y_r;
    start_x_nxt   = start_x_r;
    start_y_nxt   = start_y_r;
    box_w_nxt     = box_w_r;
    box_h_nxt     = box_h_r;
    j_adv_nxt     = j_adv_r;
    j_height_nxt  = j_height_r;
    emit          = 1'b0;
    out_data_nxt  = out_data_r;

    unique case (s1_op_r)
      OP_LOAD: begin
        if (s1_ld_metric_r) begin
          j_adv_nxt    = s1_ld_adv_r;
          j_height_nxt = s1_ld_height_r;
        end
      end
      OP_BEGIN: begin
        start_x_nxt  = s1_origin_x_r;
        start_y_nxt  = s1_origin_y_r;
        cursor_x_nxt = s1_origin_x_r;
        cursor_y_nxt = s1_origin_y_r;
        box_w_nxt    = '0;
        box_h_nxt    = '0;
      end
      OP_CHAR: begin
        if (s1_code_r == CH_SPACE) begin
          cursor_x_nxt = sat_s16(cx_ext + jadv_ext);
        end else if (s1_code_r == CH_TAB) begin
          cursor_x_nxt = sat_s16(cx_ext + $signed({8'd0, j_adv_r, 2'b00}));
        end else if (s1_code_r == CH_NEWLINE) begin
          cursor_x_nxt = start_x_r;
          cursor_y_nxt = sat_s16(cy_ext + jh_ext + 18'sd2);
        end else begin
          emit = 1'b1;
          if (rel > $signed({2'b00, box_w_r})) begin
            box_w_nxt = sat_u16(rel + jadv_ext);
          end
          box_h_nxt = sat_u16(cy_ext - sy_ext + jh_ext + $signed({10'd0, LINE_GAP}));
          out_data_nxt[11:0]   = g.atlas_x;
          out_data_nxt[23:12]  = g.atlas_y;
          out_data_nxt[31:24]  = g.width;
          out_data_nxt[39:32]  = g.height;
          out_data_nxt[55:40]  = sat_s16(cx_ext + 18'(g.offset_x));
          out_data_nxt[71:56]  = sat_s16(cy_ext + 18'(g.offset_y));
          out_data_nxt[87:72]  = box_w_nxt;
          out_data_nxt[103:88] = box_h_nxt;
          cursor_x_nxt = sat_s16(cx_ext + $signed({10'd0, g.advance}));
        end
      end
      default: begin
        // unused kind: no effect
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_x_r  <= '0;
      cursor_y_r  <= '0;
      start_x_r   <= '0;
      start_y_r   <= '0;
      box_w_r     <= '0;
      box_h_r     <= '0;
      j_adv_r     <= '0;
      j_height_r  <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r && emit;
      if (s1_valid_r) begin
        cursor_x_r <= cursor_x_nxt;
        cursor_y_r <= cursor_y_nxt;
        start_x_r  <= start_x_nxt;
        start_y_r  <= start_y_nxt;
        box_w_r    <= box_w_nxt;
        box_h_r    <= box_h_nxt;
        j_adv_r    <= j_adv_nxt;
        j_height_r <= j_height_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r && emit) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire
